// ===== rtl/ngll_pkg.sv =====
// Shared constants and a hex digit helper function for the GLL sentence parser.
`timescale 1ns / 1ps

package ngll_pkg;

  localparam int TERM_LEN_DEFAULT = 15;

  localparam int BYTE_W    = 8;
  localparam int TERM_W    = 4;
  localparam int COUNT_W   = 32;
  localparam int TAG_LEN   = 5;
  localparam int OUT_BITS  = BYTE_W + TERM_W + 5 + 4 * COUNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [TERM_W-1:0] TERM_MAX = 4'd15;
  localparam logic [TERM_W-1:0] TERM_STATUS = 4'd6;
  localparam logic [TERM_W-1:0] TERM_COORD_FIRST = 4'd1;
  localparam logic [TERM_W-1:0] TERM_COORD_LAST = 4'd4;

  localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CHAR_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CHAR_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_A      = 8'h41;

  localparam logic [BYTE_W-1:0] GLL_TAG [TAG_LEN] = '{8'h47, 8'h4E, 8'h47, 8'h4C, 8'h4C};

  // Hex digit value; anything that is not a hex digit converts as byte minus '0'.
  function automatic logic [BYTE_W-1:0] hex_digit(input logic [BYTE_W-1:0] a);
    logic [BYTE_W-1:0] d;
    if (a >= 8'h41 && a <= 8'h46) begin
      d = a - 8'h37;
    end else if (a >= 8'h61 && a <= 8'h66) begin
      d = a - 8'h57;
    end else begin
      d = a - 8'h30;
    end
    return d;
  endfunction

endpackage

// ===== rtl/nmea_gll_sentence_parser.sv =====
// GLL sentence parser: per-byte term tracking, XOR checksum check and fix counters.
`timescale 1ns / 1ps

// A byte accepted into the input register is parsed from there, and its result is
// presented on the master side from the result register (two registers deep).
// Throughput: one byte per cycle unless the master side stalls; the parse logic
// between the two registers is a few compares, an XOR and the counter increments.
// A stalled master side holds the result register and backs up into the input register.
// Reset (rst, synchronous) clears the term buffer, all parse state and all counters.
module nmea_gll_sentence_parser #(
  parameter int TERM_LEN = ngll_pkg::TERM_LEN_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ngll_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] byte_in
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [7:0] byte_echo, [11:8] term_index, [12] coord_char, [13] term_closed,
  // [14] checksum_checked, [15] checksum_ok, [16] position_ready,
  // [48:17] valid_fixes, [80:49] invalid_fixes, [112:81] passed_checksums,
  // [144:113] failed_checksums, [151:145] zero
  output logic [ngll_pkg::OUT_DATA_W-1:0]   m_tdata
);

  localparam int OFF_W = $clog2(TERM_LEN);
  localparam int BW = ngll_pkg::BYTE_W;
  localparam int TW = ngll_pkg::TERM_W;
  localparam int CW = ngll_pkg::COUNT_W;

  // Input register.
  logic          in_valid;
  logic [BW-1:0] in_byte;

  // Parse state.
  logic [BW-1:0]    term_buffer [TERM_LEN];
  logic [OFF_W-1:0] term_offset;
  logic [TW-1:0]    term_number;
  logic [BW-1:0]    running_parity;
  logic             is_gll_sentence;
  logic             in_checksum_term;
  logic             fix_status_valid;
  logic [CW-1:0]    valid_fix_counter;
  logic [CW-1:0]    invalid_fix_counter;
  logic [CW-1:0]    pass_counter;
  logic [CW-1:0]    fail_counter;

  logic [OFF_W-1:0] term_offset_next;
  logic [TW-1:0]    term_number_next;
  logic [BW-1:0]    running_parity_next;
  logic             is_gll_sentence_next;
  logic             in_checksum_term_next;
  logic             fix_status_valid_next;
  logic [CW-1:0]    valid_fix_counter_next;
  logic [CW-1:0]    invalid_fix_counter_next;
  logic [CW-1:0]    pass_counter_next;
  logic [CW-1:0]    fail_counter_next;

  logic             buf_we;
  logic [BW-1:0]    buf_wdata;

  logic [TW-1:0]    idx_next;
  logic             coord_next;
  logic             closed_next;
  logic             checked_next;
  logic             ok_next;
  logic             ready_next;

  logic             advance;
  logic             is_term_end;
  logic             is_start;
  logic [BW-1:0]    eff [6];
  logic             tag_match;
  logic [BW-1:0]    parity_closed;
  logic [BW-1:0]    dig_hi;
  logic [BW-1:0]    dig_lo;
  logic [BW-1:0]    sum;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  assign is_term_end = (in_byte == ngll_pkg::CHAR_COMMA) || (in_byte == ngll_pkg::CHAR_CR) ||
                       (in_byte == ngll_pkg::CHAR_LF) || (in_byte == ngll_pkg::CHAR_STAR);
  assign is_start = (in_byte == ngll_pkg::CHAR_DOLLAR);

  // The first six buffer bytes as seen after the terminator's zero is written.
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      eff[k] = (term_offset == OFF_W'(k)) ? '0 : term_buffer[k];
    end
    tag_match = (eff[5] == '0);
    for (int k = 0; k < ngll_pkg::TAG_LEN; k++) begin
      if (eff[k] != ngll_pkg::GLL_TAG[k]) begin
        tag_match = 1'b0;
      end
    end
  end

  assign parity_closed = (in_byte == ngll_pkg::CHAR_COMMA) ?
                         (running_parity ^ in_byte) : running_parity;
  assign dig_hi = ngll_pkg::hex_digit(eff[0]);
  assign dig_lo = ngll_pkg::hex_digit(eff[1]);
  assign sum = {dig_hi[3:0], 4'h0} + dig_lo;

  always_comb begin
    term_offset_next         = term_offset;
    term_number_next         = term_number;
    running_parity_next      = running_parity;
    is_gll_sentence_next     = is_gll_sentence;
    in_checksum_term_next    = in_checksum_term;
    fix_status_valid_next    = fix_status_valid;
    valid_fix_counter_next   = valid_fix_counter;
    invalid_fix_counter_next = invalid_fix_counter;
    pass_counter_next        = pass_counter;
    fail_counter_next        = fail_counter;
    buf_we       = 1'b0;
    buf_wdata    = in_byte;
    idx_next     = term_number;
    coord_next   = 1'b0;
    closed_next  = 1'b0;
    checked_next = 1'b0;
    ok_next      = 1'b0;
    ready_next   = 1'b0;

    if (is_term_end) begin
      running_parity_next = parity_closed;
      closed_next = 1'b1;
      buf_we      = 1'b1;
      buf_wdata   = '0;
      if (in_checksum_term) begin
        checked_next = 1'b1;
        if (sum != parity_closed) begin
          fail_counter_next = fail_counter + 1'b1;
        end else begin
          ok_next = 1'b1;
          pass_counter_next = pass_counter + 1'b1;
          if (fix_status_valid) begin
            valid_fix_counter_next = valid_fix_counter + 1'b1;
            ready_next = 1'b1;
          end else begin
            invalid_fix_counter_next = invalid_fix_counter + 1'b1;
          end
        end
      end else if (term_number == '0) begin
        is_gll_sentence_next = tag_match;
      end else if (is_gll_sentence && eff[0] != '0 && term_number == ngll_pkg::TERM_STATUS) begin
        fix_status_valid_next = (eff[0] == ngll_pkg::CHAR_A);
      end
      if (term_number != ngll_pkg::TERM_MAX) begin
        term_number_next = term_number + 1'b1;
      end
      term_offset_next = '0;
      in_checksum_term_next = (in_byte == ngll_pkg::CHAR_STAR);
    end else if (is_start) begin
      idx_next              = '0;
      term_number_next      = '0;
      term_offset_next      = '0;
      running_parity_next   = '0;
      is_gll_sentence_next  = 1'b0;
      in_checksum_term_next = 1'b0;
      fix_status_valid_next = 1'b0;
    end else begin
      if (term_offset < OFF_W'(TERM_LEN - 1)) begin
        buf_we = 1'b1;
        term_offset_next = term_offset + 1'b1;
        coord_next = is_gll_sentence && !in_checksum_term &&
                     term_number >= ngll_pkg::TERM_COORD_FIRST &&
                     term_number <= ngll_pkg::TERM_COORD_LAST;
      end
      if (!in_checksum_term) begin
        running_parity_next = running_parity ^ in_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TERM_LEN; k++) begin
        term_buffer[k] <= '0;
      end
      term_offset         <= '0;
      term_number         <= '0;
      running_parity      <= '0;
      is_gll_sentence     <= 1'b0;
      in_checksum_term    <= 1'b0;
      fix_status_valid    <= 1'b0;
      valid_fix_counter   <= '0;
      invalid_fix_counter <= '0;
      pass_counter        <= '0;
      fail_counter        <= '0;
    end else if (advance) begin
      if (buf_we) begin
        term_buffer[term_offset] <= buf_wdata;
      end
      term_offset         <= term_offset_next;
      term_number         <= term_number_next;
      running_parity      <= running_parity_next;
      is_gll_sentence     <= is_gll_sentence_next;
      in_checksum_term    <= in_checksum_term_next;
      fix_status_valid    <= fix_status_valid_next;
      valid_fix_counter   <= valid_fix_counter_next;
      invalid_fix_counter <= invalid_fix_counter_next;
      pass_counter        <= pass_counter_next;
      fail_counter        <= fail_counter_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      m_tdata <= ngll_pkg::OUT_DATA_W'({fail_counter_next, pass_counter_next,
                                        invalid_fix_counter_next, valid_fix_counter_next,
                                        ready_next, ok_next, checked_next, closed_next,
                                        coord_next, idx_next, in_byte});
    end
  end

`ifndef NO_ASSERTIONS
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input side stalled while the result register is empty");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    advance |=> term_offset <= OFF_W'(TERM_LEN - 1))
    else $error("term offset ran past the buffer");

  a_pass_count: assert property (@(posedge clk) disable iff (rst)
    advance && ok_next |=> pass_counter == $past(pass_counter) + 1'b1)
    else $error("pass counter did not follow a good checksum");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    advance && is_start |=> running_parity == '0 && term_number == '0 && !in_checksum_term)
    else $error("sentence start did not clear the parse state");

  a_ready_needs_ok: assert property (@(posedge clk) disable iff (rst)
    advance && ready_next |-> ok_next && fix_status_valid)
    else $error("position reported without a good checksum and valid fix");
`endif

endmodule

// ===== tb/gll_result_checker.sv =====
// Scoreboard for the GLL sentence parser: predicts every result and compares it field by field.
`timescale 1ns / 1ps

module gll_result_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [ngll_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] byte_in
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [ngll_pkg::OUT_DATA_W-1:0] m_tdata,   // see the result struct below
  output int                              errors,
  output int                              outstanding,
  output int                              results_seen,
  output int                              checksum_terms,
  output int                              checksums_good,
  output int                              position_fixes
);
  import ngll_pkg::*;

  // Result layout, highest bits first so that the struct maps directly onto m_tdata.
  typedef struct packed {
    logic [OUT_DATA_W-OUT_BITS-1:0] pad;
    logic [COUNT_W-1:0]             failed_checksums;
    logic [COUNT_W-1:0]             passed_checksums;
    logic [COUNT_W-1:0]             invalid_fixes;
    logic [COUNT_W-1:0]             valid_fixes;
    logic                           position_ready;
    logic                           checksum_ok;
    logic                           checksum_checked;
    logic                           term_closed;
    logic                           coord_char;
    logic [TERM_W-1:0]              term_index;
    logic [BYTE_W-1:0]              byte_echo;
  } gll_result_t;

  // Parser state as the block should hold it.
  logic [BYTE_W-1:0]  term_buf [TERM_LEN_DEFAULT];
  logic [TERM_W-1:0]  term_pos;
  logic [TERM_W-1:0]  term_num;
  logic [BYTE_W-1:0]  parity;
  logic               gll_seen;
  logic               in_sum;
  logic               fix_valid;
  logic [COUNT_W-1:0] n_valid;
  logic [COUNT_W-1:0] n_invalid;
  logic [COUNT_W-1:0] n_pass;
  logic [COUNT_W-1:0] n_fail;

  gll_result_t expected_q[$];

  function automatic logic [BYTE_W-1:0] digit_value(input logic [BYTE_W-1:0] a);
    if (a >= "A" && a <= "F") begin
      return a - 8'd55;
    end else if (a >= "a" && a <= "f") begin
      return a - 8'd87;
    end
    return a - "0";
  endfunction

  task automatic clear_state();
    for (int k = 0; k < TERM_LEN_DEFAULT; k++) term_buf[k] = '0;
    term_pos  = '0;
    term_num  = '0;
    parity    = '0;
    gll_seen  = 1'b0;
    in_sum    = 1'b0;
    fix_valid = 1'b0;
    n_valid   = '0;
    n_invalid = '0;
    n_pass    = '0;
    n_fail    = '0;
  endtask

  // Advances the predicted state by one received character and returns its result.
  task automatic parse_byte(input logic [BYTE_W-1:0] c, output gll_result_t r);
    logic [BYTE_W-1:0] d_hi;
    logic [BYTE_W-1:0] d_lo;
    logic [BYTE_W-1:0] sum;
    logic              tag_match;
    r = '0;
    r.byte_echo  = c;
    r.term_index = term_num;
    if (c == CHAR_COMMA || c == CHAR_CR || c == CHAR_LF || c == CHAR_STAR) begin
      // Only the comma of the four terminators enters the parity.
      if (c == CHAR_COMMA) parity ^= c;
      r.term_closed = 1'b1;
      if (term_pos < TERM_LEN_DEFAULT) term_buf[term_pos] = '0;
      if (in_sum) begin
        d_hi = digit_value(term_buf[0]);
        d_lo = digit_value(term_buf[1]);
        sum  = {d_hi[3:0], 4'h0} + d_lo;
        r.checksum_checked = 1'b1;
        if (sum != parity) begin
          n_fail++;
        end else begin
          r.checksum_ok = 1'b1;
          n_pass++;
          if (fix_valid) begin
            n_valid++;
            r.position_ready = 1'b1;
          end else begin
            n_invalid++;
          end
        end
      end else if (term_num == 0) begin
        tag_match = (term_buf[TAG_LEN] == 8'h00);
        for (int k = 0; k < TAG_LEN; k++) begin
          if (term_buf[k] != GLL_TAG[k]) tag_match = 1'b0;
        end
        gll_seen = tag_match;
      end else if (gll_seen && term_buf[0] != 8'h00 && term_num == TERM_STATUS) begin
        fix_valid = (term_buf[0] == CHAR_A);
      end
      if (term_num != TERM_MAX) term_num++;
      term_pos = '0;
      in_sum   = (c == CHAR_STAR);
    end else if (c == CHAR_DOLLAR) begin
      r.term_index = '0;
      term_num  = '0;
      term_pos  = '0;
      parity    = '0;
      gll_seen  = 1'b0;
      in_sum    = 1'b0;
      fix_valid = 1'b0;
    end else begin
      // Characters past the buffer are dropped but still count toward the parity outside the checksum term.
      if (term_pos < TERM_LEN_DEFAULT - 1) begin
        term_buf[term_pos] = c;
        term_pos++;
        r.coord_char = gll_seen && !in_sum &&
                       term_num >= TERM_COORD_FIRST && term_num <= TERM_COORD_LAST;
      end
      if (!in_sum) parity ^= c;
    end
    r.valid_fixes      = n_valid;
    r.invalid_fixes    = n_invalid;
    r.passed_checksums = n_pass;
    r.failed_checksums = n_fail;
  endtask

  task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                             input logic [COUNT_W-1:0] got);
    if (want !== got) begin
      errors++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    gll_result_t want;
    gll_result_t got;
    if (rst) begin
      clear_state();
      expected_q.delete();
    end else begin
      // The result side is handled first so that a result can never match a
      // byte accepted at the same edge.
      if (m_tvalid && m_tready) begin
        got = gll_result_t'(m_tdata);
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          $error("result 0x%0h arrived with no byte waiting for it", m_tdata);
        end else begin
          want = expected_q.pop_front();
          check_field("byte_echo", want.byte_echo, got.byte_echo);
          check_field("term_index", want.term_index, got.term_index);
          check_field("coord_char", want.coord_char, got.coord_char);
          check_field("term_closed", want.term_closed, got.term_closed);
          check_field("checksum_checked", want.checksum_checked, got.checksum_checked);
          check_field("checksum_ok", want.checksum_ok, got.checksum_ok);
          check_field("position_ready", want.position_ready, got.position_ready);
          check_field("valid_fixes", want.valid_fixes, got.valid_fixes);
          check_field("invalid_fixes", want.invalid_fixes, got.invalid_fixes);
          check_field("passed_checksums", want.passed_checksums, got.passed_checksums);
          check_field("failed_checksums", want.failed_checksums, got.failed_checksums);
          check_field("pad", want.pad, got.pad);
          if (want.checksum_checked) checksum_terms++;
          if (want.checksum_ok) checksums_good++;
          if (want.position_ready) position_fixes++;
        end
      end
      if (s_tvalid && s_tready) begin
        parse_byte(s_tdata, want);
        expected_q.push_back(want);
      end
    end
    outstanding = expected_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the GLL sentence parser: reset, clock, sentence stimulus and the verdict.
`timescale 1ns / 1ps

module tb;
  import ngll_pkg::*;

  localparam int RANDOM_BYTES = 1650;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int errors;
  int outstanding;
  int results_seen;
  int checksum_terms;
  int checksums_good;
  int position_fixes;

  int bytes_sent = 0;
  int burst_left = 0;
  int sentences  = 0;
  logic [BYTE_W-1:0] line_q[$];

  always #5 clk = ~clk;

  nmea_gll_sentence_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  gll_result_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .errors         (errors),
    .outstanding    (outstanding),
    .results_seen   (results_seen),
    .checksum_terms (checksum_terms),
    .checksums_good (checksums_good),
    .position_fixes (position_fixes)
  );

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Offers one byte; called at a falling edge and returns at a falling edge.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 10) return "0" + n;
    return (lower ? "a" : "A") + {4'h0, n} - 8'd10;
  endfunction

  // Ordinary term content: mostly printable, now and then a high byte.
  function automatic logic [BYTE_W-1:0] term_char();
    logic [BYTE_W-1:0] ch;
    if ($urandom_range(0, 19) == 0) return BYTE_W'($urandom_range(128, 255));
    ch = BYTE_W'($urandom_range(32, 126));
    while (ch == CHAR_COMMA || ch == CHAR_STAR || ch == CHAR_DOLLAR) begin
      ch = BYTE_W'($urandom_range(32, 126));
    end
    return ch;
  endfunction

  // Parity over everything queued after the leading '$'.
  function automatic logic [BYTE_W-1:0] line_parity();
    logic [BYTE_W-1:0] p;
    p = '0;
    for (int i = 1; i < line_q.size(); i++) p ^= line_q[i];
    return p;
  endfunction

  task automatic send_line();
    while (line_q.size() > 0) send_byte(line_q.pop_front());
  endtask

  // Builds one sentence with random content; most are well formed GNGLL sentences.
  task automatic build_sentence();
    int kind;
    int nterms;
    int len;
    logic [BYTE_W-1:0] sum;
    line_q.delete();
    line_q.push_back(CHAR_DOLLAR);
    kind = $urandom_range(0, 19);
    if (kind < 16) begin
      push_text("GNGLL");
    end else if (kind == 16) begin
      push_text("GPGLL");
    end else if (kind == 17) begin
      push_text("GNGL");
    end else if (kind == 18) begin
      push_text("GNGLLX");
    end else begin
      push_text("GNG");
      line_q.push_back(8'h00);
      push_text("LL");
    end

    kind = $urandom_range(0, 9);
    nterms = (kind == 0) ? $urandom_range(0, 5) : (kind == 1) ? $urandom_range(7, 18) : 6;
    for (int t = 1; t <= nterms; t++) begin
      line_q.push_back(CHAR_COMMA);
      if (t == 6) begin
        kind = $urandom_range(0, 19);
        if (kind < 10) begin
          line_q.push_back(CHAR_A);
        end else if (kind < 15) begin
          push_text("V");
        end else if (kind < 17) begin
          push_text("AV");
        end else if (kind < 19) begin
          line_q.push_back(term_char());
        end
      end else begin
        kind = $urandom_range(0, 9);
        len = (kind < 7) ? $urandom_range(0, 8) : (kind < 9) ? $urandom_range(9, 13) :
              $urandom_range(14, 20);
        repeat (len) line_q.push_back(term_char());
      end
    end

    // A sentence now and then never reaches its checksum.
    if ($urandom_range(0, 19) == 0) return;
    sum = line_parity();
    line_q.push_back(CHAR_STAR);
    kind = $urandom_range(0, 49);
    if (kind < 35) begin
      line_q.push_back(hex_char(sum[7:4], 1'b0));
      line_q.push_back(hex_char(sum[3:0], 1'b0));
    end else if (kind < 40) begin
      line_q.push_back(hex_char(sum[7:4], 1'b1));
      line_q.push_back(hex_char(sum[3:0], 1'b1));
    end else if (kind < 44) begin
      sum ^= BYTE_W'($urandom_range(1, 255));
      line_q.push_back(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
      line_q.push_back(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
    end else if (kind < 46) begin
      // Single digit: the second one is read from the zero that the terminator writes.
      line_q.push_back(hex_char(sum[3:0], 1'b0));
    end else if (kind < 48) begin
      // Empty checksum term.
    end else begin
      line_q.push_back(term_char());
      line_q.push_back(term_char());
      if ($urandom_range(0, 1)) line_q.push_back(term_char());
    end

    kind = $urandom_range(0, 9);
    if (kind < 8) begin
      line_q.push_back(CHAR_CR);
      line_q.push_back(CHAR_LF);
    end else if (kind == 8) begin
      line_q.push_back(CHAR_LF);
    end else begin
      line_q.push_back(CHAR_COMMA);
    end
  endtask

  // The result side alternates between free flow and several stall patterns,
  // with one long hold-off that backs the parser up into its input.
  initial begin : ready_pattern
    int mode;
    int span;
    bit held;
    held = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      if (!held && bytes_sent > 200) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (400) @(negedge clk);
      end else begin
        repeat (span) begin
          case (mode)
            0: begin
              m_tready <= 1'b1;
            end
            1: begin
              m_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
              m_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
              m_tready <= ($urandom_range(0, 7) != 0);
            end
          endcase
          @(negedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int goal;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Extreme bytes before any sentence start, then one short valid fix with a
    // lowercase checksum.
    send_byte(8'h00);
    send_byte(8'hFF);
    line_q.delete();
    line_q.push_back(CHAR_DOLLAR);
    push_text("GNGLL,4,N,,,,A");
    begin : directed_sum
      logic [BYTE_W-1:0] sum;
      sum = line_parity();
      line_q.push_back(CHAR_STAR);
      line_q.push_back(hex_char(sum[7:4], 1'b1));
      line_q.push_back(hex_char(sum[3:0], 1'b1));
    end
    line_q.push_back(CHAR_CR);
    line_q.push_back(CHAR_LF);
    send_line();

    goal = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        // Line noise: any byte value at all.
        repeat ($urandom_range(1, 20)) line_q.push_back(BYTE_W'($urandom_range(0, 255)));
      end else begin
        build_sentence();
        sentences++;
        if ($urandom_range(0, 9) == 0) begin
          while (line_q.size() > 1 && $urandom_range(0, 3) != 0) void'(line_q.pop_back());
        end
      end
      send_line();
    end
    s_tvalid <= 1'b0;

    wait (outstanding == 0);
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes in about %0d sentences plus noise; %0d results checked.",
             bytes_sent, sentences, results_seen);
    $display("Checksum terms evaluated: %0d, matching: %0d, positions ready: %0d.",
             checksum_terms, checksums_good, position_fixes);
    if (errors == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== nmea_gll_sentence_parser.f =====
rtl/ngll_pkg.sv
rtl/nmea_gll_sentence_parser.sv
tb/gll_result_checker.sv
tb/tb.sv
